// File: hw/rtl/srwp_pkg.sv
// Package for the swap readahead window prefetcher.
// Holds the address and window widths, state codes and the window choice function.
// Depends on nothing.
package srwp_pkg;

    localparam int ADDR_W     = 48;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
    localparam int HITS_W     = 8;
    localparam int ROOM_W     = 3;
    localparam int WIN_W      = 4;
    localparam int MAX_WINDOW = 8;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WIN  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    typedef enum logic [1:0] {
        ALU_DIFF = 2'b00,
        ALU_INC  = 2'b01,
        ALU_DEC  = 2'b10
    } t_alu_op;

    function automatic logic [WIN_W-1:0] f_window(
        input logic [HITS_W-1:0] hits,
        input logic              adjacent,
        input logic [WIN_W-1:0]  prev_window
    );
        logic [HITS_W+1:0] pages;
        logic [HITS_W+1:0] r;
        logic [HITS_W+1:0] floor_win;
        pages     = {2'b00, hits} + (HITS_W+2)'(2);
        r         = (HITS_W+2)'(4);
        floor_win = (HITS_W+2)'(prev_window >> 1);
        if (hits == '0) begin
            pages = adjacent ? (HITS_W+2)'(2) : (HITS_W+2)'(1);
        end else begin
            for (int k = 2; k <= HITS_W; k++) begin
                if (((HITS_W+2)'(1) << k) < pages) begin
                    r = (HITS_W+2)'(1) << (k + 1);
                end
            end
            pages = r;
        end
        if (pages > (HITS_W+2)'(MAX_WINDOW)) begin
            pages = (HITS_W+2)'(MAX_WINDOW);
        end
        if (pages < floor_win) begin
            pages = floor_win;
        end
        return pages[WIN_W-1:0];
    endfunction

endpackage

// File: hw/rtl/srwp_alu.sv
// Shared page-number adder of the prefetcher.
// Computes the page difference to the previous fault and the next page of a run.
// Depends on srwp_pkg.
module srwp_alu
    import srwp_pkg::*;
(
    input  t_alu_op           i_op,
    input  logic [PAGE_W-1:0] i_a,
    input  logic [PAGE_W-1:0] i_b,
    output logic [PAGE_W-1:0] o_sum,
    output logic              o_carry
);

    logic [PAGE_W-1:0] w_b;
    logic              w_cin;
    logic [PAGE_W:0]   w_sum;

    always_comb begin
        unique case (i_op)
            ALU_DIFF: begin
                w_b   = ~i_b;
                w_cin = 1'b1;
            end
            ALU_INC: begin
                w_b   = PAGE_W'(1);
                w_cin = 1'b0;
            end
            ALU_DEC: begin
                w_b   = '1;
                w_cin = 1'b0;
            end
            default: begin
                w_b   = '0;
                w_cin = 1'b0;
            end
        endcase
    end

    assign w_sum   = {1'b0, i_a} + {1'b0, w_b} + {{PAGE_W{1'b0}}, w_cin};
    assign o_sum   = w_sum[PAGE_W-1:0];
    assign o_carry = w_sum[PAGE_W];

endmodule

// File: hw/rtl/swap_readahead_window_prefetcher.sv
// Top level of the swap readahead window prefetcher.
// Depends on srwp_pkg and srwp_alu.
//
// channel | dir | fields (low bit first)
// s_axis  | in  | tdata: fault_address[47:0], hit_count[55:48], queue_room[58:56]
// m_axis  | out | tdata: prefetch_address[47:0], window_size[51:48]; tlast: last
//
// A fault request is taken in S_IDLE, its window is decided in S_WIN, and S_EMIT then gives one
// prefetch address per cycle while the output is not stalled, min(window-1, queue_room) in all.
// A single shared page adder does both: it finds the direction, then steps the page.
// Reset is synchronous and clears the sequencer, the output valid and the stored page and
// window. A stalled output holds its result and stops the run until it is taken.
module swap_readahead_window_prefetcher
    import srwp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // fault_address, hit_count, queue_room, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // prefetch_address, window_size, zero pad
    output logic        m_axis_tlast
);

    t_state            r_state, n_state;
    logic [PAGE_W-1:0] r_page;
    logic [HITS_W-1:0] r_hits;
    logic [ROOM_W-1:0] r_room;
    logic [PAGE_W-1:0] r_prev_page;
    logic [WIN_W-1:0]  r_prev_window;
    logic [PAGE_W-1:0] r_cur;
    logic              r_inc;
    logic [WIN_W-1:0]  r_pages;
    logic [WIN_W-1:0]  r_count;
    logic [WIN_W-1:0]  r_idx;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    logic [WIN_W-1:0]  r_out_win;
    logic              r_out_last;

    t_alu_op           w_op;
    logic [PAGE_W-1:0] w_a;
    logic [PAGE_W-1:0] w_sum;
    logic              w_carry;
    logic              w_adjacent;
    logic              w_increasing;
    logic [WIN_W-1:0]  w_pages;
    logic [WIN_W-1:0]  w_want;
    logic [WIN_W-1:0]  w_count;
    logic [WIN_W-1:0]  w_room1;
    logic              w_in_acc;
    logic              w_slot_free;
    logic              w_emit;

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_slot_free = !r_out_valid || m_axis_tready;
    assign w_emit      = (r_state == S_EMIT) && w_slot_free;

    always_comb begin
        if (r_state == S_WIN) begin
            w_op = ALU_DIFF;
            w_a  = r_page;
        end else begin
            w_op = r_inc ? ALU_INC : ALU_DEC;
            w_a  = r_cur;
        end
    end

    srwp_alu u_alu (
        .i_op    (w_op),
        .i_a     (w_a),
        .i_b     (r_prev_page),
        .o_sum   (w_sum),
        .o_carry (w_carry)
    );

    assign w_adjacent   = (w_sum == PAGE_W'(1)) || (w_sum == {PAGE_W{1'b1}});
    assign w_increasing = w_carry && (w_sum != '0);
    assign w_pages      = f_window(r_hits, w_adjacent, r_prev_window);
    assign w_want       = w_pages - WIN_W'(1);
    assign w_count      = (w_want < WIN_W'(r_room)) ? w_want : WIN_W'(r_room);
    assign w_room1      = WIN_W'(r_room) + WIN_W'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_WIN;
                end
            end
            S_WIN: begin
                n_state = (w_count == '0) ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (w_emit && (r_idx == r_count)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_prev_page   <= '0;
            r_prev_window <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_WIN) begin
                r_prev_page   <= r_page;
                r_prev_window <= (w_pages < w_room1) ? w_pages : w_room1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_page <= s_axis_tdata[PAGE_SHIFT +: PAGE_W];
            r_hits <= s_axis_tdata[ADDR_W +: HITS_W];
            r_room <= s_axis_tdata[ADDR_W+HITS_W +: ROOM_W];
        end
        if (r_state == S_WIN) begin
            r_cur   <= r_page;
            r_inc   <= w_increasing;
            r_pages <= w_pages;
            r_count <= w_count;
            r_idx   <= WIN_W'(1);
        end
        if (w_emit) begin
            r_cur      <= w_sum;
            r_idx      <= r_idx + WIN_W'(1);
            r_out_addr <= {w_sum, {PAGE_SHIFT{1'b0}}};
            r_out_win  <= r_pages;
            r_out_last <= (r_idx == r_count);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_win, r_out_addr};
    assign m_axis_tlast  = r_out_last;

endmodule

// File: hw/rtl/srwp_checker.sv
// Port checker for the swap readahead window prefetcher, bound to the top level.
// Depends on the top level's port list only.
module srwp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("Stalled result changed.");

    a_win_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[51:48] >= 4'd2) && (m_axis_tdata[51:48] <= 4'd8)
            && (m_axis_tdata[11:0] == 12'd0) && (m_axis_tdata[55:52] == 4'd0))
        else $error("Result has a bad window or an unaligned address.");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Ready again right after a request.");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("Request taken in the middle of a run.");

endmodule

bind swap_readahead_window_prefetcher srwp_checker u_srwp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
